FILE: hdl/harvard_accumulator_cpu_core_macros.svh
// Assertion macros shared by the CPU core RTL.
`ifndef HARVARD_ACCUMULATOR_CPU_CORE_MACROS_SVH
`define HARVARD_ACCUMULATOR_CPU_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HACC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hacc_pkg.sv
// Types, codes and decode helpers for the Harvard accumulator CPU core.
package hacc_pkg;

  localparam int RAM_ADDRESS_BITS_DEF = 15;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    OP_LD  = 3'd0,
    OP_AND = 3'd1,
    OP_OR  = 3'd2,
    OP_XOR = 3'd3,
    OP_ADD = 3'd4,
    OP_SUB = 3'd5,
    OP_ST  = 3'd6,
    OP_BR  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    MODE_D_AC    = 3'd0,
    MODE_X_AC    = 3'd1,
    MODE_YD_AC   = 3'd2,
    MODE_YX_AC   = 3'd3,
    MODE_D_X     = 3'd4,
    MODE_D_Y     = 3'd5,
    MODE_D_OUT   = 3'd6,
    MODE_YXI_OUT = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    SRC_D   = 2'd0,
    SRC_RAM = 2'd1,
    SRC_AC  = 2'd2,
    SRC_IN  = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_AC   = 3'd1,
    DST_X    = 3'd2,
    DST_Y    = 3'd3,
    DST_OUT  = 3'd4
  } dst_t;

  // Branch mode that jumps far to Y:bus; the others test AC within the page.
  localparam logic [2:0] BR_FAR = 3'd0;

  // Full 16-bit data address Y:D style, before folding onto the RAM size.
  function automatic logic [15:0] data_addr(input logic [7:0] ir, input logic [7:0] d,
                                            input logic [7:0] x, input logic [7:0] y);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = d;
    hi = 8'd0;
    if (op_t'(ir[7:5]) != OP_BR) begin
      unique case (mode_t'(ir[4:2]))
        MODE_X_AC: begin
          lo = x;
        end
        MODE_YD_AC: begin
          hi = y;
        end
        MODE_YX_AC, MODE_YXI_OUT: begin
          lo = x;
          hi = y;
        end
        MODE_D_AC, MODE_D_X, MODE_D_Y, MODE_D_OUT: begin
          lo = d;
        end
        default: begin
          lo = d;
        end
      endcase
    end
    return {hi, lo};
  endfunction

endpackage

FILE: hdl/harvard_accumulator_cpu_core.sv
// Top level of the Harvard 8-bit accumulator CPU core with its data RAM.
//
// Usage: each input transaction is one machine cycle. in_tdata carries the program
// word fetched at the address reported by the previous output transaction (after
// reset that address is 0), plus the input port byte and the byte a store drives
// when its bus source is undefined. The core executes the previously latched
// instruction (so the word after a branch, the delay slot, always executes) and
// then latches the new word. Each input transaction yields exactly one output
// transaction with the next fetch address and the output register.
// Throughput is one instruction per clock while in_tready is high: the data RAM is
// read ahead, at the address of the instruction being latched, so its registered
// read port never stalls; a store in the same cycle to that address is forwarded.
// Each result is registered into a two-entry output queue, so a new transaction is
// accepted while a result still waits; only when both entries are full (the receiver
// stalling) or the RAM is still being cleared does in_tready fall.
// After reset the RAM is swept to zero, one byte per cycle, across all 2**RAM_ADDRESS_BITS
// addresses (32768 by default); in_tready stays low meanwhile.
module harvard_accumulator_cpu_core
  import hacc_pkg::*;
#(
  parameter int RAM_ADDRESS_BITS = RAM_ADDRESS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fetched_opcode[7:0], fetched_operand[15:8], input_port[23:16], undefined_byte[31:24]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // fetch_address[15:0], out_port[23:16]
  output logic [OUT_DATA_W-1:0] out_tdata
);

`include "harvard_accumulator_cpu_core_macros.svh"

  localparam int RAM_DEPTH = 1 << RAM_ADDRESS_BITS;
  localparam int AW        = RAM_ADDRESS_BITS;

  // Architectural state.
  logic [7:0]  ac_r, x_r, y_r, outr_r;
  logic [15:0] pc_r;
  logic [7:0]  ir_r, d_r;

  // Data RAM, clear sweep and read-ahead path.
  logic [7:0]    mem [RAM_DEPTH];
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;
  logic [7:0]    mem_rd_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;

  // Output queue.
  logic [OUT_DATA_W-1:0] q_r [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            cnt_r;

  logic in_fire, out_fire;
  assign in_tready  = !clearing_r && (cnt_r != 2'd2);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign out_tdata  = q_r[rd_ptr_r];

  // Execute the latched instruction.
  op_t   op_w;
  mode_t mode_w;
  src_t  src_w;
  dst_t  dst_w;
  logic  is_store, is_branch, incx;
  logic [15:0] ea_cur;
  logic [7:0]  ram_q, bus, alu;
  logic [7:0]  ac_nxt, x_nxt, y_nxt, outr_nxt;
  logic [15:0] pc_nxt, pc_inc;
  logic [1:0]  cond;
  logic        taken;
  logic [15:0] ea_next;

  assign op_w      = op_t'(ir_r[7:5]);
  assign mode_w    = mode_t'(ir_r[4:2]);
  assign src_w     = src_t'(ir_r[1:0]);
  assign is_store  = (op_w == OP_ST);
  assign is_branch = (op_w == OP_BR);
  assign ea_cur    = data_addr(ir_r, d_r, x_r, y_r);
  assign ram_q     = fwd_hit_r ? fwd_data_r : mem_rd_r;
  assign pc_inc    = pc_r + 16'd1;

  always_comb begin
    dst_w = DST_NONE;
    incx  = 1'b0;
    if (!is_branch) begin
      unique case (mode_w)
        MODE_D_AC, MODE_X_AC, MODE_YD_AC, MODE_YX_AC: dst_w = DST_AC;
        MODE_D_X:   dst_w = DST_X;
        MODE_D_Y:   dst_w = DST_Y;
        MODE_D_OUT: dst_w = DST_OUT;
        MODE_YXI_OUT: begin
          dst_w = DST_OUT;
          incx  = 1'b1;
        end
        default: dst_w = DST_NONE;
      endcase
      // A store only writes X or Y besides memory; other targets are dropped.
      if (is_store && (dst_w != DST_X) && (dst_w != DST_Y)) begin
        dst_w = DST_NONE;
      end
    end
  end

  always_comb begin
    case (src_w)
      SRC_D:   bus = d_r;
      SRC_RAM: bus = is_store ? in_tdata[31:24] : ram_q;
      SRC_AC:  bus = ac_r;
      default: bus = in_tdata[23:16];
    endcase
  end

  always_comb begin
    case (op_w)
      OP_LD:   alu = bus;
      OP_AND:  alu = ac_r & bus;
      OP_OR:   alu = ac_r | bus;
      OP_XOR:  alu = ac_r ^ bus;
      OP_ADD:  alu = ac_r + bus;
      OP_SUB:  alu = ac_r - bus;
      default: alu = ac_r;
    endcase
  end

  always_comb begin
    ac_nxt   = ac_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    outr_nxt = outr_r;
    case (dst_w)
      DST_AC:  ac_nxt = alu;
      DST_X:   x_nxt = alu;
      DST_Y:   y_nxt = alu;
      DST_OUT: outr_nxt = alu;
      default: ;
    endcase
    if (incx) begin
      x_nxt = x_r + 8'd1;
    end
  end

  // Conditional branches look at AC as signed: zero, negative, or positive.
  assign cond  = (ac_r == 8'd0) ? 2'd2 : (ac_r[7] ? 2'd1 : 2'd0);
  assign taken = ir_r[3'd2 + {1'b0, cond}];

  always_comb begin
    pc_nxt = pc_inc;
    if (is_branch) begin
      if (ir_r[4:2] == BR_FAR) begin
        pc_nxt = {y_r, bus};
      end else if (taken) begin
        pc_nxt = {pc_r[15:8], bus};
      end
    end
  end

  // Address the instruction being latched will use, with X and Y as they will be.
  assign ea_next = data_addr(in_tdata[7:0], in_tdata[15:8], x_nxt, y_nxt);

  // Architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_r   <= '0;
      x_r    <= '0;
      y_r    <= '0;
      outr_r <= '0;
      pc_r   <= '0;
      ir_r   <= '0;
      d_r    <= '0;
    end else if (in_fire) begin
      ac_r   <= ac_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      outr_r <= outr_nxt;
      pc_r   <= pc_nxt;
      ir_r   <= in_tdata[7:0];
      d_r    <= in_tdata[15:8];
    end
  end

  // Clear sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (&clr_addr_r) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_fire) begin
        fwd_hit_r <= is_store && (ea_cur[AW-1:0] == ea_next[AW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= bus;
    end
  end

  // RAM: one write port (clear sweep or store) and one registered read port.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= 8'd0;
    end else if (in_fire && is_store) begin
      mem[ea_cur[AW-1:0]] <= bus;
    end
    if (in_fire) begin
      mem_rd_r <= mem[ea_next[AW-1:0]];
    end
  end

  // Two-entry output queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (out_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (in_fire && !out_fire) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (out_fire && !in_fire) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_r[wr_ptr_r] <= {outr_nxt, pc_nxt};
    end
  end

  // Checks.
  `HACC_ASSERT_NEXT(a_pc_step, in_fire && !is_branch, pc_r == $past(pc_r) + 16'd1, "pc did not step")
  `HACC_ASSERT_NEXT(a_x_postinc, in_fire && incx, x_r == $past(x_r) + 8'd1, "X not incremented")
  `HACC_ASSERT_NEXT(a_q_fill, in_fire && !out_fire, cnt_r == $past(cnt_r) + 2'd1, "queue count")

endmodule
